### hdl/grmc_pkg.sv
// shared types, constants and tables for the grid ray march column block
`default_nettype none
package grmc_pkg;

	localparam int NUM_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;
	localparam int MAX_STEPS_DEF   = 160;
	localparam int HALF_FOV_BAM    = 5461;
	localparam int CELL_UNIT       = 163840;
	localparam int MAP_SIZE        = 16;
	localparam int NUM_REGS        = 4;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] view_angle;
		logic [6:0]  column;
	} grmc_in_t;

	typedef struct packed {
		logic [6:0] column_out;
		logic       ray_hit;
		logic [7:0] march_steps;
		logic [7:0] wall_height;
		logic       has_rows;
		logic [4:0] first_row;
		logic [4:0] last_row;
		logic       near_shade;
	} grmc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_TRIG,
		ST_MARCH,
		ST_DIV,
		ST_ROWS,
		ST_DONE
	} grmc_state_t;

	// quarter-wave sine, q14
	function automatic logic [14:0] sin_quarter(input logic [6:0] j);
		logic [14:0] r;
		case (j)
			7'd0: r = 15'd0;      7'd1: r = 15'd402;    7'd2: r = 15'd804;
			7'd3: r = 15'd1205;   7'd4: r = 15'd1606;   7'd5: r = 15'd2006;
			7'd6: r = 15'd2404;   7'd7: r = 15'd2801;   7'd8: r = 15'd3196;
			7'd9: r = 15'd3590;   7'd10: r = 15'd3981;  7'd11: r = 15'd4370;
			7'd12: r = 15'd4756;  7'd13: r = 15'd5139;  7'd14: r = 15'd5520;
			7'd15: r = 15'd5897;  7'd16: r = 15'd6270;  7'd17: r = 15'd6639;
			7'd18: r = 15'd7005;  7'd19: r = 15'd7366;  7'd20: r = 15'd7723;
			7'd21: r = 15'd8076;  7'd22: r = 15'd8423;  7'd23: r = 15'd8765;
			7'd24: r = 15'd9102;  7'd25: r = 15'd9434;  7'd26: r = 15'd9760;
			7'd27: r = 15'd10080; 7'd28: r = 15'd10394; 7'd29: r = 15'd10702;
			7'd30: r = 15'd11003; 7'd31: r = 15'd11297; 7'd32: r = 15'd11585;
			7'd33: r = 15'd11866; 7'd34: r = 15'd12140; 7'd35: r = 15'd12406;
			7'd36: r = 15'd12665; 7'd37: r = 15'd12916; 7'd38: r = 15'd13160;
			7'd39: r = 15'd13395; 7'd40: r = 15'd13623; 7'd41: r = 15'd13842;
			7'd42: r = 15'd14053; 7'd43: r = 15'd14256; 7'd44: r = 15'd14449;
			7'd45: r = 15'd14635; 7'd46: r = 15'd14811; 7'd47: r = 15'd14978;
			7'd48: r = 15'd15137; 7'd49: r = 15'd15286; 7'd50: r = 15'd15426;
			7'd51: r = 15'd15557; 7'd52: r = 15'd15679; 7'd53: r = 15'd15791;
			7'd54: r = 15'd15893; 7'd55: r = 15'd15986; 7'd56: r = 15'd16069;
			7'd57: r = 15'd16143; 7'd58: r = 15'd16207; 7'd59: r = 15'd16261;
			7'd60: r = 15'd16305; 7'd61: r = 15'd16340; 7'd62: r = 15'd16364;
			7'd63: r = 15'd16379; 7'd64: r = 15'd16384;
			default: r = 15'd0;
		endcase
		return r;
	endfunction

	// signed sine on a 256-step circle
	function automatic logic signed [15:0] sin_idx(input logic [7:0] idx);
		logic [6:0]  j;
		logic [14:0] m;
		j = {1'b0, idx[5:0]};
		m = idx[6] ? sin_quarter(7'd64 - j) : sin_quarter(j);
		return idx[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage
`default_nettype wire

### hdl/grmc_march.sv
// march unit: one step of the ray per cycle with one shared cell test
`default_nettype none
module grmc_march #(
	parameter int MAX_STEPS = grmc_pkg::MAX_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [15:0]         pos_x,
	input  wire logic [15:0]         pos_y,
	input  wire logic signed [15:0]  dx,
	input  wire logic signed [15:0]  dy,
	input  wire logic [255:0]        map_bits,
	output logic                     busy,
	output logic                     hit,
	output logic [$clog2(MAX_STEPS+1)-1:0] steps
);
	import grmc_pkg::*;

	localparam int KW = $clog2(MAX_STEPS + 1);

	logic signed [23:0] nx_q, ny_q;
	logic [KW-1:0]      k_q;
	logic               busy_q, hit_q;
	logic signed [23:0] tx, ty;
	logic               out_x, out_y, wall;
	logic [3:0]         cx, cy;
	logic [15:0]        px_mul, py_mul;

	// point after the next step
	assign tx = nx_q + 24'(dx);
	assign ty = ny_q + 24'(dy);

	// truncation toward zero, edge test
	// cell = (n >> 15) / 5, the divide by 5 as a multiply by 205 and shift by 10
	always_comb begin
		out_x = (tx <= -24'sd163840) || (tx >= 24'sd2621440);
		out_y = (ty <= -24'sd163840) || (ty >= 24'sd2621440);
		px_mul = 16'(tx[22:15]) * 16'd205;
		py_mul = 16'(ty[22:15]) * 16'd205;
		cx = tx[23] ? 4'd0 : px_mul[13:10];
		cy = ty[23] ? 4'd0 : py_mul[13:10];
		wall = map_bits[{cx, cy}];
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hit_q  <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			hit_q  <= 1'b0;
			k_q    <= '0;
		end else if (busy_q) begin
			k_q <= k_q + 1'b1;
			if (out_x || out_y || wall) begin
				hit_q  <= 1'b1;
				busy_q <= 1'b0;
			end else if (k_q + 1'b1 == KW'(MAX_STEPS)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// ray point accumulators
	always_ff @(posedge clk) begin
		if (start) begin
			nx_q <= 24'(pos_x) * 24'sd40;
			ny_q <= 24'(pos_y) * 24'sd40;
		end else if (busy_q) begin
			nx_q <= tx;
			ny_q <= ty;
		end
	end

	assign busy  = busy_q;
	assign hit   = hit_q;
	assign steps = k_q;
endmodule
`default_nettype wire

### hdl/grid_ray_march_column.sv
// grid_ray_march_column: casts one column ray through a 16x16 wall map
// an accepted item passes the angle, trig, march, divide and row states before its result is offered
// the march unit takes one step per cycle; height uses a shift-subtract divider
// one item at a time: no new item is taken until the result has been taken, so an output stall also holds the input
// reset: map registers clear to zero, the sequencer returns to idle, no result is held
`default_nettype none
module grid_ray_march_column #(
	parameter int NUM_COLUMNS = grmc_pkg::NUM_COLUMNS_DEF,
	parameter int SCREEN_ROWS = grmc_pkg::SCREEN_ROWS_DEF,
	parameter int MAX_STEPS   = grmc_pkg::MAX_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire grmc_pkg::grmc_in_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output grmc_pkg::grmc_out_t      out_item,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic [63:0]              prdata,
	output logic                     pready
);
	import grmc_pkg::*;

	localparam int KW  = $clog2(MAX_STEPS + 1);
	localparam int RW  = $clog2(SCREEN_ROWS * 10 + 1);
	localparam int BW  = $clog2(RW);
	localparam int CW  = (RW + 1 > KW) ? RW + 1 : KW;
	localparam int OFS_DIV = 6 * NUM_COLUMNS;
	localparam int OFS_SH  = 23 + $clog2(OFS_DIV);
	localparam longint OFS_MUL = ((longint'(1) << OFS_SH) + OFS_DIV - 1) / OFS_DIV;
	localparam int CENTER  = SCREEN_ROWS / 2;

	grmc_state_t state_q, state_d;
	logic [63:0] map_q [NUM_REGS];
	logic [255:0] map_bits;
	grmc_in_t    in_q;
	logic [15:0] ray_q;
	logic signed [15:0] dx_q, dy_q;
	logic [RW-1:0] num_q;
	logic [RW-1:0] rem_q, quo_q;
	logic [BW-1:0] bit_q;
	logic        mstart, mbusy, mhit;
	logic [KW-1:0] msteps, k_eff;
	grmc_out_t   res_q;
	logic [7:0]  idx;
	logic [31:0] ofs_prod;
	logic [CW-1:0] trial;
	logic signed [RW+1:0] lo, hi;
	logic [RW-1:0] half;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) map_q[i] <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			map_q[paddr[4:3]] <= pwdata;
		end
	end
	assign prdata = map_q[paddr[4:3]];
	assign map_bits = {map_q[3], map_q[2], map_q[1], map_q[0]};

	grmc_march #(.MAX_STEPS(MAX_STEPS)) u_march (
		.clk, .arst_n, .start(mstart), .pos_x(in_q.pos_x), .pos_y(in_q.pos_y),
		.dx(dx_q), .dy(dy_q), .map_bits, .busy(mbusy), .hit(mhit), .steps(msteps)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		mstart  = 1'b0;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ANGLE;
			ST_ANGLE: state_d = ST_TRIG;
			ST_TRIG:  begin state_d = ST_MARCH; mstart = 1'b1; end
			ST_MARCH: if (!mbusy && !mstart) state_d = ST_DIV;
			ST_DIV:   if (bit_q == '0) state_d = ST_ROWS;
			ST_ROWS:  state_d = ST_DONE;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// column offset column*65536/(6*NUM_COLUMNS) by reciprocal multiply
	assign ofs_prod = 32'(in_q.column) * 32'(OFS_MUL);

	assign idx   = 8'((ray_q + 16'd128) >> 8);
	assign k_eff = (msteps == '0) ? KW'(1) : msteps;
	assign trial = CW'({rem_q, num_q[bit_q]});
	assign half  = quo_q >> 1;
	assign lo = (RW+2)'(CENTER) - $signed({2'b0, half});
	assign hi = (RW+2)'(CENTER) + $signed({2'b0, half}) - (RW+2)'(1);

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) in_q <= in_item;
			ST_ANGLE: ray_q <= 16'(in_q.view_angle
				+ 16'(ofs_prod >> (OFS_SH - 16)) - 16'(HALF_FOV_BAM));
			ST_TRIG: begin
				dx_q <= sin_idx(idx + 8'd64);
				dy_q <= sin_idx(idx);
				num_q <= RW'(SCREEN_ROWS * 10);
				rem_q <= '0;
				quo_q <= '0;
				bit_q <= BW'(RW - 1);
			end
			ST_DIV: begin
				if (trial >= CW'(k_eff)) begin
					rem_q <= RW'(trial - CW'(k_eff));
					quo_q <= quo_q | (RW'(1) << bit_q);
				end else begin
					rem_q <= RW'(trial);
				end
				if (bit_q != 0) bit_q <= bit_q - 1'b1;
			end
			ST_ROWS: begin
				res_q.column_out  <= in_q.column;
				res_q.ray_hit     <= mhit;
				res_q.march_steps <= (k_eff > 255) ? 8'd255 : 8'(k_eff);
				res_q.wall_height <= (quo_q > 255) ? 8'd255 : 8'(quo_q);
				res_q.near_shade  <= k_eff < KW'(MAX_STEPS / 2);
				if ((lo < 0 ? 0 : lo) <= (hi > SCREEN_ROWS-1 ? SCREEN_ROWS-1 : hi)) begin
					res_q.has_rows  <= 1'b1;
					res_q.first_row <= lo < 0 ? 5'd0 : 5'(lo);
					res_q.last_row  <= hi > SCREEN_ROWS-1 ? 5'(SCREEN_ROWS-1) : 5'(hi);
				end else begin
					res_q.has_rows  <= 1'b0;
					res_q.first_row <= 5'd0;
					res_q.last_row  <= 5'd0;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign out_item  = res_q;
endmodule
`default_nettype wire

### hdl/grmc_checker.sv
// port checker for the grid ray march column block
`default_nettype none
module grmc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire grmc_pkg::grmc_out_t out_item
);
	import grmc_pkg::*;

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("item taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second item taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("result dropped");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.march_steps != 8'd0) else $error("zero steps");
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.has_rows |-> out_item.first_row <= out_item.last_row)
		else $error("row span reversed");
endmodule

bind grid_ray_march_column grmc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);
`default_nettype wire

### tb/tb_grid_ray_march_column.sv
// testbench for the grid ray march column block: directed and random rays against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_grid_ray_march_column;
	import grmc_pkg::*;

	localparam int NCOLS = 80;
	localparam int NROWS = 25;
	localparam int NSTEPS = 160;
	localparam int POS_SCALE = 40;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [4:0] ADDR_MAP0 = 5'd0;
	localparam logic [4:0] ADDR_MAP1 = 5'd8;
	localparam logic [4:0] ADDR_MAP2 = 5'd16;
	localparam logic [4:0] ADDR_MAP3 = 5'd24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	grmc_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	grmc_out_t out_item;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	logic [63:0] wall_map [4];
	grmc_out_t slice_queue [$];
	int errors = 0;
	int cycles = 0;
	bit send_idle_en = 1'b0;
	bit recv_idle_en = 1'b0;
	bit hold_recv = 1'b0;

	grid_ray_march_column dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// quarter-wave sine in q14
	function automatic int quarter_sin(int j);
		int tbl [65] = '{0, 402, 804, 1205, 1606, 2006, 2404, 2801,
			3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
			6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
			9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
			11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
			13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
			15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
			16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};
		return tbl[j];
	endfunction

	function automatic int circle_sin(int idx);
		int j;
		j = idx & 63;
		case ((idx >> 6) & 3)
			0: return quarter_sin(j);
			1: return quarter_sin(64 - j);
			2: return -quarter_sin(j);
			default: return -quarter_sin(64 - j);
		endcase
	endfunction

	// map coordinate in 1/163840 cell to a cell, -1 when off the map
	function automatic int to_cell(longint n);
		longint c;
		if (n < 0) return (-n >= CELL_UNIT) ? -1 : 0;
		c = n / CELL_UNIT;
		return (c >= MAP_SIZE) ? -1 : int'(c);
	endfunction

	function automatic grmc_out_t cast_slice(grmc_in_t it);
		grmc_out_t r;
		int offs, ray, idx, dx, dy, k, cx, cy, h, half, lo, hi;
		bit hit;
		offs = (int'(it.column) * 65536) / (6 * NCOLS);
		ray = (int'(it.view_angle) + offs + 65536 - HALF_FOV_BAM) & 16'hffff;
		idx = ((ray + 128) >> 8) & 255;
		dx = circle_sin((idx + 64) & 255);
		dy = circle_sin(idx);
		k = 0;
		hit = 1'b0;
		while (k < NSTEPS && !hit) begin
			k++;
			cx = to_cell(longint'(it.pos_x) * POS_SCALE + longint'(dx) * k);
			cy = to_cell(longint'(it.pos_y) * POS_SCALE + longint'(dy) * k);
			if (cx < 0 || cy < 0) hit = 1'b1;
			else if (wall_map[cx >> 2][((cx & 3) << 4) + cy]) hit = 1'b1;
		end
		h = (NROWS * 10) / k;
		half = h / 2;
		lo = NROWS / 2 - half;
		hi = NROWS / 2 + half - 1;
		if (lo < 0) lo = 0;
		if (hi > NROWS - 1) hi = NROWS - 1;
		r.column_out = it.column;
		r.ray_hit = hit;
		r.march_steps = (k > 255) ? 8'd255 : 8'(k);
		r.wall_height = (h > 255) ? 8'd255 : 8'(h);
		r.has_rows = (lo <= hi);
		r.first_row = (lo <= hi) ? 5'(lo) : 5'd0;
		r.last_row = (lo <= hi) ? 5'(hi) : 5'd0;
		r.near_shade = (k < NSTEPS / 2);
		return r;
	endfunction

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_recv) out_stall <= 1'b1;
		else if (recv_idle_en) out_stall <= ($urandom_range(99) < 28);
		else out_stall <= 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		grmc_out_t exp_slice;
		if (arst_n && out_valid && !out_stall) begin
			if (slice_queue.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_item);
				errors++;
			end else begin
				exp_slice = slice_queue.pop_front();
				if (out_item.column_out !== exp_slice.column_out) begin
					$display("%0t column_out exp %0d got %0d", $time,
						exp_slice.column_out, out_item.column_out); errors++; end
				if (out_item.ray_hit !== exp_slice.ray_hit) begin
					$display("%0t ray_hit exp %0d got %0d", $time,
						exp_slice.ray_hit, out_item.ray_hit); errors++; end
				if (out_item.march_steps !== exp_slice.march_steps) begin
					$display("%0t march_steps exp %0d got %0d", $time,
						exp_slice.march_steps, out_item.march_steps); errors++; end
				if (out_item.wall_height !== exp_slice.wall_height) begin
					$display("%0t wall_height exp %0d got %0d", $time,
						exp_slice.wall_height, out_item.wall_height); errors++; end
				if (out_item.has_rows !== exp_slice.has_rows) begin
					$display("%0t has_rows exp %0d got %0d", $time,
						exp_slice.has_rows, out_item.has_rows); errors++; end
				if (out_item.first_row !== exp_slice.first_row) begin
					$display("%0t first_row exp %0d got %0d", $time,
						exp_slice.first_row, out_item.first_row); errors++; end
				if (out_item.last_row !== exp_slice.last_row) begin
					$display("%0t last_row exp %0d got %0d", $time,
						exp_slice.last_row, out_item.last_row); errors++; end
				if (out_item.near_shade !== exp_slice.near_shade) begin
					$display("%0t near_shade exp %0d got %0d", $time,
						exp_slice.near_shade, out_item.near_shade); errors++; end
			end
		end
	end

	// register write over the config port, setup then access
	task automatic write_map(input int idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 5'(idx * 8); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		wall_map[idx] = value;
	endtask

	task automatic load_map(input logic [63:0] m0, m1, m2, m3);
		write_map(ADDR_MAP0 / 8, m0);
		write_map(ADDR_MAP1 / 8, m1);
		write_map(ADDR_MAP2 / 8, m2);
		write_map(ADDR_MAP3 / 8, m3);
	endtask

	// send one item, random idle gaps before it
	task automatic send_ray(input grmc_in_t it);
		@(posedge clk);
		while (send_idle_en && $urandom_range(99) < 28) @(posedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		slice_queue.push_back(cast_slice(it));
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (slice_queue.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic grmc_in_t rand_ray(bit inside_map);
		grmc_in_t it;
		it.pos_x = inside_map ? 16'($urandom_range(65535 - 4096, 4096)) : 16'($urandom);
		it.pos_y = inside_map ? 16'($urandom_range(65535 - 4096, 4096)) : 16'($urandom);
		it.view_angle = 16'($urandom);
		it.column = ($urandom_range(19) == 0) ? 7'($urandom_range(127, 80))
			: 7'($urandom_range(NCOLS - 1));
		return it;
	endfunction

	task automatic test_edges;
		grmc_in_t it;
		load_map('0, '0, '0, '0);
		// corners, field extremes, column beyond screen
		it = '{16'h0000, 16'h0000, 16'h0000, 7'd0}; send_ray(it);
		it = '{16'hffff, 16'hffff, 16'hffff, 7'd79}; send_ray(it);
		it = '{16'h8000, 16'h8000, 16'h4000, 7'd40}; send_ray(it);
		it = '{16'h8000, 16'h8000, 16'h8000, 7'd127}; send_ray(it);
		it = '{16'h8000, 16'h8000, 16'hc000, 7'd80}; send_ray(it);
		it = '{16'h0800, 16'h8000, 16'h8000, 7'd40}; send_ray(it);
		it = '{16'h0001, 16'h0001, 16'hc000, 7'd40}; send_ray(it);
		drain();
		// open field middle: rays along an axis and a diagonal run out to the map edge
		it = '{16'h8000, 16'h8000, 16'h0000, 7'd40}; send_ray(it);
		it = '{16'h7fff, 16'h7fff, 16'h2000, 7'd40}; send_ray(it);
		drain();
		// full walls: hit in the first step, largest height, rows clamped to the screen
		load_map('1, '1, '1, '1);
		it = '{16'h8000, 16'h8000, 16'h0000, 7'd0}; send_ray(it);
		it = '{16'h5555, 16'haaaa, 16'h5555, 7'd63}; send_ray(it);
		drain();
		// border ring only
		load_map(64'h0000_0000_0000_ffff | 64'h8001_8001_8001_0000,
			64'h8001_8001_8001_8001, 64'h8001_8001_8001_8001,
			64'hffff_8001_8001_8001);
		for (int a = 0; a < 8; a++) begin
			it = '{16'h8000, 16'h8000, 16'(a * 8192), 7'(a * 10)}; send_ray(it);
		end
		drain();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0) begin
				drain();
				// sparse maps keep rays long, dense ones short
				case ($urandom_range(3))
					0: load_map('0, '0, '0, '0);
					1: load_map({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
						{$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
						{$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
						{$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
					2: load_map({$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, {$urandom, $urandom});
					default: load_map('1, {$urandom, $urandom}, '0, '1);
				endcase
			end
			send_ray(rand_ray($urandom_range(3) != 0));
		end
	endtask

	task automatic test_backpressure;
		drain();
		load_map('0, 64'h0000_0000_0000_0001, '0, '0);
		fork
			begin
				hold_recv = 1'b1;
				repeat (1500) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int n = 0; n < 12; n++) send_ray(rand_ray(1'b1));
		join
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		// long stretch with no idling, then random idling on both sides
		test_random(250);
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		test_backpressure();
		test_random(750);
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
hdl/grmc_pkg.sv
hdl/grmc_march.sv
hdl/grid_ray_march_column.sv
hdl/grmc_checker.sv
tb/tb_grid_ray_march_column.sv
